// ===== rtl/limit_order_matching_book_assert.svh =====
// Assertion macros used by the checker file lomb_chk.
`ifndef LIMIT_ORDER_MATCHING_BOOK_ASSERT_SVH
`define LIMIT_ORDER_MATCHING_BOOK_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define LOMB_AST_IMPLY(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lomb check failed: lbl");

// Next-cycle implication, held off during reset.
`define LOMB_AST_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lomb check failed: lbl");

`endif

// ===== rtl/lomb_pkg.sv =====
// ----------------------------------------------------------------------------
// lomb_pkg
// Shared constants, codes and sequencer states of the order matching book.
// ----------------------------------------------------------------------------
package lomb_pkg;

  localparam int TICKERS_DEF    = 1024;
  localparam int BOOK_DEPTH_DEF = 16;

  localparam int TICKER_W = 10;
  localparam int QTY_W    = 16;
  localparam int PRICE_W  = 16;
  localparam int ENTRY_W  = QTY_W + PRICE_W;

  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  localparam logic [1:0] ST_FILLED  = 2'd0;
  localparam logic [1:0] ST_RESTED  = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CNT_RD,
    S_CNT_WAIT,
    S_ENT_RD,
    S_ENT_CHK,
    S_TRADE_OUT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_CNT_WB,
    S_OWN_WAIT,
    S_DONE_OUT
  } state_t;

endpackage

// ===== rtl/limit_order_matching_book.sv =====
// An ignored order shows its completion beat the cycle after acceptance; a matched
// order walks the opposite book, with a trade beat per fill, removal of each emptied
// entry and closing up of the entries after it, then shows its completion beat.
// One order at a time; out_ready can stall trade and completion beats.
// Reset clears the count of every book before the first order is taken.
// ----------------------------------------------------------------------------
// limit_order_matching_book
// Per-ticker buy and sell books; matches one limit order against the opposite
// book, newest first, emitting trade beats and one completion beat.
// ----------------------------------------------------------------------------
module limit_order_matching_book #(
  parameter int TICKERS    = lomb_pkg::TICKERS_DEF,
  parameter int BOOK_DEPTH = lomb_pkg::BOOK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lomb_pkg::TICKER_W-1:0] in_ticker,
  input  logic                         in_side,
  input  logic [lomb_pkg::QTY_W-1:0]   in_quantity,
  input  logic [lomb_pkg::PRICE_W-1:0] in_price,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_result_kind,
  output logic [lomb_pkg::QTY_W-1:0]   out_trade_quantity,
  output logic [lomb_pkg::PRICE_W-1:0] out_trade_price,
  output logic [lomb_pkg::QTY_W-1:0]   out_rested_quantity,
  output logic [1:0]                   out_status,
  output logic                         out_last_item
);

  localparam int BOOKS  = 2 * TICKERS;
  localparam int BW     = (BOOKS > 1) ? $clog2(BOOKS) : 1;
  localparam int ENTRYS = BOOKS * BOOK_DEPTH;
  localparam int EAW    = (ENTRYS > 1) ? $clog2(ENTRYS) : 1;
  localparam int CW     = $clog2(BOOK_DEPTH + 1);
  localparam int QW     = lomb_pkg::QTY_W;
  localparam int PW     = lomb_pkg::PRICE_W;
  localparam int EW     = lomb_pkg::ENTRY_W;

  lomb_pkg::state_t state_r, state_nxt;

  logic [BW-1:0]  clr_r, clr_nxt;
  logic           side_r, side_nxt;
  logic [QW-1:0]  qty_r, qty_nxt;
  logic [PW-1:0]  price_r, price_nxt;
  logic [BW-1:0]  own_r, own_nxt, opp_r, opp_nxt;
  logic [EAW-1:0] own_base_r, own_base_nxt, opp_base_r, opp_base_nxt;
  logic [CW-1:0]  ocnt_r, ocnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic           remove_r, remove_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          o_kind_r, o_kind_nxt;
  logic [QW-1:0] o_tq_r, o_tq_nxt;
  logic [PW-1:0] o_tp_r, o_tp_nxt;
  logic [QW-1:0] o_rq_r, o_rq_nxt;
  logic [1:0]    o_st_r, o_st_nxt;

  logic           e_we;
  logic [EAW-1:0] e_waddr, e_raddr;
  logic [EW-1:0]  e_wdata, e_rdata;
  logic           c_we;
  logic [BW-1:0]  c_waddr, c_raddr;
  logic [CW-1:0]  c_wdata, c_rdata;

  logic           ignore;
  logic [13:0]    book_wide;
  logic [BW-1:0]  book_in;
  logic [QW-1:0]  rq, tq;
  logic [PW-1:0]  rp, buy_p, sell_p;
  logic           crossing;

  lomb_ram #(.WIDTH(EW), .DEPTH(ENTRYS)) u_entries (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  lomb_ram #(.WIDTH(CW), .DEPTH(BOOKS)) u_counts (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  assign ignore    = (in_quantity == '0) || (14'(in_ticker) >= 14'(TICKERS));
  assign book_wide = {3'b000, in_ticker, 1'b0};
  assign book_in   = BW'(book_wide);

  assign rq       = e_rdata[EW-1:PW];
  assign rp       = e_rdata[PW-1:0];
  assign buy_p    = side_r ? rp : price_r;
  assign sell_p   = side_r ? price_r : rp;
  assign crossing = (buy_p >= sell_p) && (rq != '0);
  assign tq       = (qty_r < rq) ? qty_r : rq;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lomb_pkg::S_CLEAR: begin
        if (clr_r == BW'(BOOKS - 1)) state_nxt = lomb_pkg::S_IDLE;
      end
      lomb_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ignore ? lomb_pkg::S_DONE_OUT : lomb_pkg::S_CNT_RD;
      end
      lomb_pkg::S_CNT_RD:   state_nxt = lomb_pkg::S_CNT_WAIT;
      lomb_pkg::S_CNT_WAIT: state_nxt = lomb_pkg::S_ENT_RD;
      lomb_pkg::S_ENT_RD: begin
        state_nxt = (i_r == '0 || qty_r == '0) ? lomb_pkg::S_CNT_WB : lomb_pkg::S_ENT_CHK;
      end
      lomb_pkg::S_ENT_CHK: begin
        state_nxt = crossing ? lomb_pkg::S_TRADE_OUT : lomb_pkg::S_ENT_RD;
      end
      lomb_pkg::S_TRADE_OUT: begin
        if (out_ready) state_nxt = remove_r ? lomb_pkg::S_SHIFT_RD : lomb_pkg::S_ENT_RD;
      end
      lomb_pkg::S_SHIFT_RD: begin
        state_nxt = ((CW + 1)'(j_r) + 1'b1 < (CW + 1)'(ocnt_r)) ?
                    lomb_pkg::S_SHIFT_WR : lomb_pkg::S_ENT_RD;
      end
      lomb_pkg::S_SHIFT_WR: state_nxt = lomb_pkg::S_SHIFT_RD;
      lomb_pkg::S_CNT_WB: begin
        state_nxt = (qty_r == '0) ? lomb_pkg::S_DONE_OUT : lomb_pkg::S_OWN_WAIT;
      end
      lomb_pkg::S_OWN_WAIT: state_nxt = lomb_pkg::S_DONE_OUT;
      lomb_pkg::S_DONE_OUT: begin
        if (out_ready) state_nxt = lomb_pkg::S_IDLE;
      end
      default: state_nxt = lomb_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_nxt       = clr_r;
    side_nxt      = side_r;
    qty_nxt       = qty_r;
    price_nxt     = price_r;
    own_nxt       = own_r;
    opp_nxt       = opp_r;
    own_base_nxt  = own_base_r;
    opp_base_nxt  = opp_base_r;
    ocnt_nxt      = ocnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    remove_nxt    = remove_r;
    out_valid_nxt = out_valid_r;
    o_kind_nxt    = o_kind_r;
    o_tq_nxt      = o_tq_r;
    o_tp_nxt      = o_tp_r;
    o_rq_nxt      = o_rq_r;
    o_st_nxt      = o_st_r;
    e_we          = 1'b0;
    e_waddr       = opp_base_r + EAW'(i_r);
    e_wdata       = {qty_r, price_r};
    e_raddr       = opp_base_r + EAW'(i_r);
    c_we          = 1'b0;
    c_waddr       = opp_r;
    c_wdata       = ocnt_r;
    c_raddr       = opp_r;
    case (state_r)
      lomb_pkg::S_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_r;
        c_wdata = '0;
        clr_nxt = clr_r + 1'b1;
      end
      lomb_pkg::S_IDLE: begin
        if (in_valid) begin
          side_nxt     = in_side;
          qty_nxt      = in_quantity;
          price_nxt    = in_price;
          own_nxt      = book_in | BW'(in_side);
          opp_nxt      = book_in | BW'(!in_side);
          own_base_nxt = EAW'((book_in | BW'(in_side)) * BOOK_DEPTH);
          opp_base_nxt = EAW'((book_in | BW'(!in_side)) * BOOK_DEPTH);
          if (ignore) begin
            out_valid_nxt = 1'b1;
            o_kind_nxt    = lomb_pkg::KIND_DONE;
            o_tq_nxt      = '0;
            o_tp_nxt      = '0;
            o_rq_nxt      = '0;
            o_st_nxt      = lomb_pkg::ST_IGNORED;
          end
        end
      end
      lomb_pkg::S_CNT_RD: begin
        c_raddr = opp_r;
      end
      lomb_pkg::S_CNT_WAIT: begin
        ocnt_nxt = c_rdata;
        i_nxt    = c_rdata;
      end
      lomb_pkg::S_ENT_RD: begin
        if (i_r != '0 && qty_r != '0) begin
          i_nxt   = i_r - 1'b1;
          e_raddr = opp_base_r + EAW'(i_r - 1'b1);
        end
      end
      lomb_pkg::S_ENT_CHK: begin
        if (crossing) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = lomb_pkg::KIND_TRADE;
          o_tq_nxt      = tq;
          o_tp_nxt      = sell_p;
          o_rq_nxt      = '0;
          o_st_nxt      = lomb_pkg::ST_FILLED;
          qty_nxt       = qty_r - tq;
          remove_nxt    = (rq == tq);
          j_nxt         = i_r;
          // partial fill: write back the reduced resting quantity
          e_we    = (rq != tq);
          e_waddr = opp_base_r + EAW'(i_r);
          e_wdata = {rq - tq, rp};
        end
      end
      lomb_pkg::S_TRADE_OUT: begin
        if (out_ready) out_valid_nxt = 1'b0;
      end
      lomb_pkg::S_SHIFT_RD: begin
        if ((CW + 1)'(j_r) + 1'b1 < (CW + 1)'(ocnt_r)) begin
          e_raddr = opp_base_r + EAW'(j_r) + 1'b1;
        end else begin
          ocnt_nxt = ocnt_r - 1'b1;
        end
      end
      lomb_pkg::S_SHIFT_WR: begin
        // close up: move the newer entry one place down
        e_we    = 1'b1;
        e_waddr = opp_base_r + EAW'(j_r);
        e_wdata = e_rdata;
        j_nxt   = j_r + 1'b1;
      end
      lomb_pkg::S_CNT_WB: begin
        c_we    = 1'b1;
        c_waddr = opp_r;
        c_wdata = ocnt_r;
        c_raddr = own_r;
        if (qty_r == '0) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = lomb_pkg::KIND_DONE;
          o_tq_nxt      = '0;
          o_tp_nxt      = '0;
          o_rq_nxt      = '0;
          o_st_nxt      = lomb_pkg::ST_FILLED;
        end
      end
      lomb_pkg::S_OWN_WAIT: begin
        out_valid_nxt = 1'b1;
        o_kind_nxt    = lomb_pkg::KIND_DONE;
        o_tq_nxt      = '0;
        o_tp_nxt      = '0;
        if ((CW + 1)'(c_rdata) < (CW + 1)'(BOOK_DEPTH)) begin
          e_we     = 1'b1;
          e_waddr  = own_base_r + EAW'(c_rdata);
          e_wdata  = {qty_r, price_r};
          c_we     = 1'b1;
          c_waddr  = own_r;
          c_wdata  = c_rdata + 1'b1;
          o_rq_nxt = qty_r;
          o_st_nxt = lomb_pkg::ST_RESTED;
        end else begin
          o_rq_nxt = '0;
          o_st_nxt = lomb_pkg::ST_DROPPED;
        end
      end
      lomb_pkg::S_DONE_OUT: begin
        if (out_ready) out_valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lomb_pkg::S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r     <= side_nxt;
    qty_r      <= qty_nxt;
    price_r    <= price_nxt;
    own_r      <= own_nxt;
    opp_r      <= opp_nxt;
    own_base_r <= own_base_nxt;
    opp_base_r <= opp_base_nxt;
    ocnt_r     <= ocnt_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    remove_r   <= remove_nxt;
    o_kind_r   <= o_kind_nxt;
    o_tq_r     <= o_tq_nxt;
    o_tp_r     <= o_tp_nxt;
    o_rq_r     <= o_rq_nxt;
    o_st_r     <= o_st_nxt;
  end

  assign in_ready            = (state_r == lomb_pkg::S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_result_kind     = o_kind_r;
  assign out_trade_quantity  = o_tq_r;
  assign out_trade_price     = o_tp_r;
  assign out_rested_quantity = o_rq_r;
  assign out_status          = o_st_r;
  assign out_last_item       = o_kind_r;

endmodule

// ===== rtl/lomb_ram.sv =====
// ----------------------------------------------------------------------------
// lomb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lomb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lomb_chk.sv =====
// ----------------------------------------------------------------------------
// lomb_chk
// Port-level checks on the order matching book, bound to the top level.
// ----------------------------------------------------------------------------
`include "limit_order_matching_book_assert.svh"

module lomb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_result_kind,
  input logic [15:0] out_rested_quantity,
  input logic [1:0]  out_status,
  input logic        out_last_item
);

  logic trade_beat;
  logic trade_clean;

  assign trade_beat  = out_valid && (out_result_kind == lomb_pkg::KIND_TRADE);
  assign trade_clean = (out_rested_quantity == 16'd0) && (out_status == lomb_pkg::ST_FILLED);

  // one order at a time: no new order is taken while a result is pending
  `LOMB_AST_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `LOMB_AST_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `LOMB_AST_IMPLY(a_last_is_done, clk, rst_n, out_valid, out_last_item == out_result_kind)
  `LOMB_AST_IMPLY(a_trade_clean, clk, rst_n, trade_beat, trade_clean)
  `LOMB_AST_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

bind limit_order_matching_book lomb_chk u_lomb_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_result_kind(out_result_kind),
  .out_rested_quantity(out_rested_quantity), .out_status(out_status),
  .out_last_item(out_last_item)
);
